@@ sv/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// Shared constants, types and helpers of the buddy block allocator: pool
// geometry, status codes, the leaf table entry, and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package bba_pkg;

   // pool geometry
   localparam int POOL_UNITS = 1024;
   localparam int MIN_BLOCK  = 32;
   localparam int LEAVES     = POOL_UNITS / MIN_BLOCK;
   localparam int LEAF_W     = $clog2(LEAVES);
   localparam int MIN_SHIFT  = $clog2(MIN_BLOCK);
   localparam int POOL_ORDER = $clog2(LEAVES);
   localparam int ORDER_W    = 3;

   // field widths
   localparam int SIZE_W   = 11;
   localparam int OFFSET_W = 10;
   localparam int STATUS_W = 2;

   // command codes
   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_NOFIT   = 2'd1,
      STATUS_BADSIZE = 2'd2,
      STATUS_BADOFF  = 2'd3
   } status_type;

   // one leaf of the block table
   typedef struct packed {
      logic                head;
      logic [ORDER_W-1:0]  order;
      logic                used;
   } leaf_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECODE,
      ST_SCAN,
      ST_SPLIT,
      ST_FREE_CHECK,
      ST_MERGE,
      ST_RESPOND
   } state_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_LOAD,
      OP_SCAN,
      OP_SPLIT,
      OP_ALLOC_COMMIT,
      OP_FREE_CHECK,
      OP_MERGE,
      OP_FREE_COMMIT
   } dp_op_type;

   typedef enum logic [1:0] {
      RD_SCAN,
      RD_LEAF,
      RD_BUDDY
   } rd_sel_type;

   typedef struct packed {
      dp_op_type   op;
      rd_sel_type  rd_sel;
      logic        rsp_load;
      status_type  rsp_code;
   } ctrl_cmd_type;

   typedef struct packed {
      logic is_free;
      logic req_zero;
      logic misaligned;
      logic scan_last;
      logic found;
      logic split_more;
      logic free_ok;
      logic merge_ok;
      logic rsp_busy;
   } dp_status_type;

   // units spanned by a block of the given order
   function automatic logic [SIZE_W-1:0] blk_size(input logic [ORDER_W-1:0] order);
      blk_size = SIZE_W'(MIN_BLOCK) << order;
   endfunction

endpackage

@@ sv/bba_datapath.sv @@
// ----------------------------------------------------------------------------
// bba_datapath
// Leaf table, scan and split/merge working registers and the result
// register. Performs one table read and at most one table write per cycle,
// as the controller commands.
// ----------------------------------------------------------------------------
module bba_datapath (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_command,
   input  logic [bba_pkg::SIZE_W-1:0]      req_request_size,
   input  logic [bba_pkg::OFFSET_W-1:0]    req_free_offset,
   input  bba_pkg::ctrl_cmd_type           ctrl,
   output bba_pkg::dp_status_type          stat,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bba_pkg::OFFSET_W-1:0]    rsp_block_offset,
   output logic [bba_pkg::SIZE_W-1:0]      rsp_block_size
);

   // leaf table
   bba_pkg::leaf_type leaf_ff [bba_pkg::LEAVES];

   // working registers
   logic                           cmd_ff, cmd_in;
   logic [bba_pkg::SIZE_W-1:0]     size_ff, size_in;
   logic                           misaligned_ff, misaligned_in;
   logic [bba_pkg::LEAF_W-1:0]     idx_ff, idx_in;
   logic [bba_pkg::LEAF_W-1:0]     work_leaf_ff, work_leaf_in;
   logic [bba_pkg::ORDER_W-1:0]    work_ord_ff, work_ord_in;
   logic                           found_ff, found_in;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [bba_pkg::STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [bba_pkg::OFFSET_W-1:0]   rsp_offset_ff, rsp_offset_in;
   logic [bba_pkg::SIZE_W-1:0]     rsp_size_ff, rsp_size_in;

   // table access
   logic [bba_pkg::LEAF_W-1:0]     rd_addr;
   bba_pkg::leaf_type              rd_entry;
   logic [bba_pkg::SIZE_W-1:0]     rd_size;
   logic [bba_pkg::SIZE_W-1:0]     best_size;
   logic [bba_pkg::LEAF_W-1:0]     buddy;
   logic [bba_pkg::LEAF_W-1:0]     merge_lo;
   logic [bba_pkg::LEAF_W-1:0]     merge_hi;
   logic [bba_pkg::ORDER_W-1:0]    ord_dec;
   logic                           scan_hit;
   logic                           wr_en;
   logic [bba_pkg::LEAF_W-1:0]     wr_addr;
   bba_pkg::leaf_type              wr_entry;

   // buddy of the current block and the merge pair
   assign buddy    = work_leaf_ff ^ (bba_pkg::LEAF_W'(1) << work_ord_ff);
   assign merge_lo = (work_leaf_ff < buddy) ? work_leaf_ff : buddy;
   assign merge_hi = (work_leaf_ff < buddy) ? buddy : work_leaf_ff;
   assign ord_dec  = work_ord_ff - bba_pkg::ORDER_W'(1);

   // single read port
   always_comb begin
      case (ctrl.rd_sel)
         bba_pkg::RD_SCAN:  rd_addr = idx_ff;
         bba_pkg::RD_LEAF:  rd_addr = work_leaf_ff;
         bba_pkg::RD_BUDDY: rd_addr = buddy;
         default:           rd_addr = idx_ff;
      endcase
   end

   assign rd_entry  = leaf_ff[rd_addr];
   assign rd_size   = bba_pkg::blk_size(rd_entry.order);
   assign best_size = bba_pkg::blk_size(work_ord_ff);

   // free block that fits and is no larger than the best so far
   assign scan_hit = rd_entry.head && !rd_entry.used &&
                     (rd_size >= size_ff) && (rd_size <= best_size);

   // status towards the controller
   always_comb begin
      stat.is_free    = (cmd_ff == bba_pkg::CMD_FREE);
      stat.req_zero   = (size_ff == '0);
      stat.misaligned = misaligned_ff;
      stat.scan_last  = (idx_ff == bba_pkg::LEAF_W'(bba_pkg::LEAVES - 1));
      stat.found      = found_ff;
      stat.split_more = (work_ord_ff != '0) &&
                        ({size_ff, 1'b0} <= {1'b0, best_size});
      stat.free_ok    = rd_entry.head && rd_entry.used;
      stat.merge_ok   = (work_ord_ff < bba_pkg::ORDER_W'(bba_pkg::POOL_ORDER)) &&
                        rd_entry.head && !rd_entry.used &&
                        (rd_entry.order == work_ord_ff);
      stat.rsp_busy   = rsp_valid_ff && rsp_stall;
   end

   // working register updates and table write port
   always_comb begin
      cmd_in        = cmd_ff;
      size_in       = size_ff;
      misaligned_in = misaligned_ff;
      idx_in        = idx_ff;
      work_leaf_in  = work_leaf_ff;
      work_ord_in   = work_ord_ff;
      found_in      = found_ff;
      wr_en         = 1'b0;
      wr_addr       = work_leaf_ff;
      wr_entry      = '0;
      case (ctrl.op)
         bba_pkg::OP_LOAD: begin
            cmd_in        = req_command;
            size_in       = req_request_size;
            misaligned_in = (req_free_offset[bba_pkg::MIN_SHIFT-1:0] != '0);
            work_leaf_in  = req_free_offset[bba_pkg::OFFSET_W-1:bba_pkg::MIN_SHIFT];
            work_ord_in   = bba_pkg::ORDER_W'(bba_pkg::POOL_ORDER);
            idx_in        = '0;
            found_in      = 1'b0;
         end
         bba_pkg::OP_SCAN: begin
            idx_in = idx_ff + bba_pkg::LEAF_W'(1);
            if (scan_hit) begin
               found_in     = 1'b1;
               work_leaf_in = idx_ff;
               work_ord_in  = rd_entry.order;
            end
         end
         bba_pkg::OP_SPLIT: begin
            // upper half becomes a free block, lower half is kept
            work_ord_in = ord_dec;
            wr_en       = 1'b1;
            wr_addr     = work_leaf_ff | (bba_pkg::LEAF_W'(1) << ord_dec);
            wr_entry    = '{head: 1'b1, order: ord_dec, used: 1'b0};
         end
         bba_pkg::OP_ALLOC_COMMIT: begin
            wr_en    = 1'b1;
            wr_entry = '{head: 1'b1, order: work_ord_ff, used: 1'b1};
         end
         bba_pkg::OP_FREE_CHECK: begin
            if (stat.free_ok) begin
               wr_en       = 1'b1;
               wr_entry    = '{head: 1'b1, order: rd_entry.order, used: 1'b0};
               work_ord_in = rd_entry.order;
            end
         end
         bba_pkg::OP_MERGE: begin
            // upper block of the pair disappears into the lower one
            wr_en        = 1'b1;
            wr_addr      = merge_hi;
            wr_entry     = '0;
            work_leaf_in = merge_lo;
            work_ord_in  = work_ord_ff + bba_pkg::ORDER_W'(1);
         end
         bba_pkg::OP_FREE_COMMIT: begin
            wr_en    = 1'b1;
            wr_entry = '{head: 1'b1, order: work_ord_ff, used: 1'b0};
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_offset_in = rsp_offset_ff;
      rsp_size_in   = rsp_size_ff;
      if (ctrl.rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ctrl.rsp_code;
         if (ctrl.rsp_code == bba_pkg::STATUS_OK) begin
            rsp_offset_in = bba_pkg::OFFSET_W'(work_leaf_ff) << bba_pkg::MIN_SHIFT;
            rsp_size_in   = best_size;
         end else begin
            rsp_offset_in = '0;
            rsp_size_in   = '0;
         end
      end
   end

   // leaf table storage
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < bba_pkg::LEAVES; i++) begin
            leaf_ff[i] <= '0;
         end
         leaf_ff[0] <= '{head: 1'b1,
                         order: bba_pkg::ORDER_W'(bba_pkg::POOL_ORDER),
                         used: 1'b0};
      end else if (wr_en) begin
         leaf_ff[wr_addr] <= wr_entry;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      size_ff       <= size_in;
      misaligned_ff <= misaligned_in;
      idx_ff        <= idx_in;
      work_leaf_ff  <= work_leaf_in;
      work_ord_ff   <= work_ord_in;
      rsp_status_ff <= rsp_status_in;
      rsp_offset_ff <= rsp_offset_in;
      rsp_size_ff   <= rsp_size_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_block_offset = rsp_offset_ff;
   assign rsp_block_size   = rsp_size_ff;

endmodule

@@ sv/bba_controller.sv @@
// ----------------------------------------------------------------------------
// bba_controller
// Sequencer of the allocator: takes one request beat, steps the datapath
// through scan and split for allocate, or check and merge for free, and
// hands the outcome to the result register.
// ----------------------------------------------------------------------------
module bba_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  bba_pkg::dp_status_type   stat,
   output bba_pkg::ctrl_cmd_type    ctrl
);

   bba_pkg::state_type  state_ff, state_in;
   bba_pkg::status_type code_ff, code_in;

   // next state
   always_comb begin
      state_in = state_ff;
      code_in  = code_ff;
      case (state_ff)
         bba_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = bba_pkg::ST_DECODE;
            end
         end
         bba_pkg::ST_DECODE: begin
            if (stat.is_free) begin
               if (stat.misaligned) begin
                  code_in  = bba_pkg::STATUS_BADOFF;
                  state_in = bba_pkg::ST_RESPOND;
               end else begin
                  state_in = bba_pkg::ST_FREE_CHECK;
               end
            end else if (stat.req_zero) begin
               code_in  = bba_pkg::STATUS_BADSIZE;
               state_in = bba_pkg::ST_RESPOND;
            end else begin
               state_in = bba_pkg::ST_SCAN;
            end
         end
         bba_pkg::ST_SCAN: begin
            if (stat.scan_last) begin
               state_in = bba_pkg::ST_SPLIT;
            end
         end
         bba_pkg::ST_SPLIT: begin
            if (!stat.found) begin
               code_in  = bba_pkg::STATUS_NOFIT;
               state_in = bba_pkg::ST_RESPOND;
            end else if (!stat.split_more) begin
               code_in  = bba_pkg::STATUS_OK;
               state_in = bba_pkg::ST_RESPOND;
            end
         end
         bba_pkg::ST_FREE_CHECK: begin
            if (stat.free_ok) begin
               state_in = bba_pkg::ST_MERGE;
            end else begin
               code_in  = bba_pkg::STATUS_BADOFF;
               state_in = bba_pkg::ST_RESPOND;
            end
         end
         bba_pkg::ST_MERGE: begin
            if (!stat.merge_ok) begin
               code_in  = bba_pkg::STATUS_OK;
               state_in = bba_pkg::ST_RESPOND;
            end
         end
         bba_pkg::ST_RESPOND: begin
            if (!stat.rsp_busy) begin
               state_in = bba_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = bba_pkg::ST_IDLE;
         end
      endcase
   end

   // datapath commands
   always_comb begin
      ctrl.op       = bba_pkg::OP_NONE;
      ctrl.rd_sel   = bba_pkg::RD_SCAN;
      ctrl.rsp_load = 1'b0;
      ctrl.rsp_code = code_ff;
      req_stall     = 1'b1;
      case (state_ff)
         bba_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               ctrl.op = bba_pkg::OP_LOAD;
            end
         end
         bba_pkg::ST_SCAN: begin
            ctrl.op     = bba_pkg::OP_SCAN;
            ctrl.rd_sel = bba_pkg::RD_SCAN;
         end
         bba_pkg::ST_SPLIT: begin
            if (stat.found) begin
               ctrl.op = stat.split_more ? bba_pkg::OP_SPLIT : bba_pkg::OP_ALLOC_COMMIT;
            end
         end
         bba_pkg::ST_FREE_CHECK: begin
            ctrl.op     = bba_pkg::OP_FREE_CHECK;
            ctrl.rd_sel = bba_pkg::RD_LEAF;
         end
         bba_pkg::ST_MERGE: begin
            ctrl.rd_sel = bba_pkg::RD_BUDDY;
            ctrl.op     = stat.merge_ok ? bba_pkg::OP_MERGE : bba_pkg::OP_FREE_COMMIT;
         end
         bba_pkg::ST_RESPOND: begin
            ctrl.rsp_load = !stat.rsp_busy;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bba_pkg::ST_IDLE;
         code_ff  <= bba_pkg::STATUS_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

endmodule

@@ sv/buddy_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit
// Buddy allocator over a 1024-unit pool in 32-unit leaves: allocate takes
// the smallest fitting free block (highest address on ties) and splits it
// down; free releases a used block and merges it with free buddies.
// ----------------------------------------------------------------------------
//
//  channel  | direction | ports                                   | beat
//  ---------+-----------+-----------------------------------------+---------------
//  req      | in        | command, request_size, free_offset      | valid & !stall
//  rsp      | out       | status, block_offset, block_size        | valid & !stall
//
//  allocate: intake and decode, a scan of the leaf table (one leaf per
//    cycle on its single read port), split steps and a commit, then the
//    result is posted.
//  free: a check of the block, then one merge step per cycle; an offset
//    that holds no used block is reported without merging.
//  errors found at decode are reported without a scan or a merge.
//  one request at a time; a new request is taken while the previous result
//    still waits in the output register, and a stalled result only holds
//    the finish of the following request.
//  synchronous reset leaves the whole pool as one free block.
//
module buddy_block_allocator_unit (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic                            req_command,
   input  logic [bba_pkg::SIZE_W-1:0]      req_request_size,
   input  logic [bba_pkg::OFFSET_W-1:0]    req_free_offset,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [bba_pkg::OFFSET_W-1:0]    rsp_block_offset,
   output logic [bba_pkg::SIZE_W-1:0]      rsp_block_size
);

   bba_pkg::ctrl_cmd_type  ctrl;
   bba_pkg::dp_status_type stat;

   // sequencer
   bba_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .stat      (stat),
      .ctrl      (ctrl)
   );

   // leaf table and result register
   bba_datapath u_dp (
      .clock            (clock),
      .reset            (reset),
      .req_command      (req_command),
      .req_request_size (req_request_size),
      .req_free_offset  (req_free_offset),
      .ctrl             (ctrl),
      .stat             (stat),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_size   (rsp_block_size)
   );

endmodule

@@ sv/bba_checker.sv @@
// ----------------------------------------------------------------------------
// bba_checker
// Port-level checks of the buddy block allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bba_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic [bba_pkg::STATUS_W-1:0]    rsp_status,
   input logic [bba_pkg::OFFSET_W-1:0]    rsp_block_offset,
   input logic [bba_pkg::SIZE_W-1:0]      rsp_block_size
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_block_offset) && $stable(rsp_block_size))
      else $error("result beat changed while stalled");

   // error results carry no block
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != bba_pkg::STATUS_OK) |->
      (rsp_block_offset == '0) && (rsp_block_size == '0))
      else $error("error result with non-zero block");

   // a good result is a real block aligned to its own size
   a_ok_aligned: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == bba_pkg::STATUS_OK) |->
      (rsp_block_size != '0) &&
      (((bba_pkg::SIZE_W'(rsp_block_offset)) & (rsp_block_size - 1'b1)) == '0))
      else $error("good result block misaligned or empty");

   // one request in work at a time
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

endmodule

bind buddy_block_allocator_unit bba_checker u_bba_checker (.*);

@@ tb/buddy_alloc_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_alloc_checker
// Watches the request and response channels of the buddy block allocator,
// keeps its own copy of the leaf table to predict the response to each
// accepted request beat, and compares every response beat field by field
// against the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module buddy_alloc_checker
   import bba_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic                 req_command,
   input  logic [SIZE_W-1:0]    req_request_size,
   input  logic [OFFSET_W-1:0]  req_free_offset,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [STATUS_W-1:0]  rsp_status,
   input  logic [OFFSET_W-1:0]  rsp_block_offset,
   input  logic [SIZE_W-1:0]    rsp_block_size,
   output int                   mismatch_count,
   output int                   pending_results
);

   typedef struct packed {
      status_type           status;
      logic [OFFSET_W-1:0]  offset;
      logic [SIZE_W-1:0]    size;
   } outcome_t;

   // shadow leaf table
   logic                leaf_head [LEAVES];
   logic [ORDER_W-1:0]  leaf_ord  [LEAVES];
   logic                leaf_busy [LEAVES];

   // predicted responses, oldest first
   outcome_t            outcome_q [$];

   function automatic int units_of(input int ord);
      return MIN_BLOCK << ord;
   endfunction

   // whole pool as one free block
   function automatic void clear_table();
      for (int i = 0; i < LEAVES; i++) begin
         leaf_head[i] = 1'b0;
         leaf_ord[i]  = '0;
         leaf_busy[i] = 1'b0;
      end
      leaf_head[0] = 1'b1;
      leaf_ord[0]  = ORDER_W'(POOL_ORDER);
   endfunction

   // best fit, highest address on ties, then split down keeping the lower half
   function automatic outcome_t predict_alloc(input int want);
      outcome_t res;
      int       best;
      int       best_units;
      int       ord;
      int       upper;
      bit       found;
      res        = '0;
      best       = 0;
      best_units = POOL_UNITS;
      found      = 1'b0;
      if (want == 0) begin
         res.status = STATUS_BADSIZE;
         return res;
      end
      for (int i = 0; i < LEAVES; i++) begin
         if (leaf_head[i] && !leaf_busy[i] && units_of(leaf_ord[i]) >= want &&
             units_of(leaf_ord[i]) <= best_units) begin
            best       = i;
            best_units = units_of(leaf_ord[i]);
            found      = 1'b1;
         end
      end
      if (!found) begin
         res.status = STATUS_NOFIT;
         return res;
      end
      ord = leaf_ord[best];
      while (ord > 0 && 2 * want <= units_of(ord)) begin
         ord--;
         upper = best + (1 << ord);
         leaf_head[upper] = 1'b1;
         leaf_ord[upper]  = ORDER_W'(ord);
         leaf_busy[upper] = 1'b0;
      end
      leaf_ord[best]  = ORDER_W'(ord);
      leaf_busy[best] = 1'b1;
      res.status = STATUS_OK;
      res.offset = OFFSET_W'(best * MIN_BLOCK);
      res.size   = SIZE_W'(units_of(ord));
      return res;
   endfunction

   // release a used block and merge upwards while the buddy is free and alike
   function automatic outcome_t predict_free(input int off);
      outcome_t res;
      int       leaf;
      int       ord;
      int       buddy;
      int       lo;
      int       hi;
      res = '0;
      if (off % MIN_BLOCK != 0 || off / MIN_BLOCK >= LEAVES) begin
         res.status = STATUS_BADOFF;
         return res;
      end
      leaf = off / MIN_BLOCK;
      if (!leaf_head[leaf] || !leaf_busy[leaf]) begin
         res.status = STATUS_BADOFF;
         return res;
      end
      leaf_busy[leaf] = 1'b0;
      ord = leaf_ord[leaf];
      while (ord < POOL_ORDER) begin
         buddy = leaf ^ (1 << ord);
         if (buddy >= LEAVES || !leaf_head[buddy] || leaf_busy[buddy] ||
             leaf_ord[buddy] != ord)
            break;
         lo = (leaf < buddy) ? leaf : buddy;
         hi = (leaf < buddy) ? buddy : leaf;
         leaf_head[hi] = 1'b0;
         leaf_ord[hi]  = '0;
         leaf_busy[hi] = 1'b0;
         ord++;
         leaf_ord[lo] = ORDER_W'(ord);
         leaf = lo;
      end
      res.status = STATUS_OK;
      res.offset = OFFSET_W'(leaf * MIN_BLOCK);
      res.size   = SIZE_W'(units_of(ord));
      return res;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   // compare response beats first, then predict from request beats
   always @(posedge clock) begin
      outcome_t oldest;
      if (reset) begin
         clear_table();
         outcome_q.delete();
         mismatch_count  = 0;
         pending_results <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (outcome_q.size() == 0) begin
               report_mismatch($sformatf("response beat with none expected (status %0d)",
                                         rsp_status));
            end else begin
               oldest = outcome_q.pop_front();
               if (rsp_status !== oldest.status)
                  report_mismatch($sformatf("status got %0d, want %0d",
                                            rsp_status, oldest.status));
               if (rsp_block_offset !== oldest.offset)
                  report_mismatch($sformatf("block_offset got %0d, want %0d",
                                            rsp_block_offset, oldest.offset));
               if (rsp_block_size !== oldest.size)
                  report_mismatch($sformatf("block_size got %0d, want %0d",
                                            rsp_block_size, oldest.size));
            end
         end
         if (req_valid && !req_stall) begin
            if (req_command == CMD_ALLOC)
               outcome_q.push_back(predict_alloc(req_request_size));
            else
               outcome_q.push_back(predict_free(req_free_offset));
         end
         pending_results <= outcome_q.size();
      end
   end

endmodule

@@ tb/buddy_block_allocator_unit_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// buddy_block_allocator_unit_test
// Drives allocate and free requests into the buddy block allocator: a short
// directed run over the error cases, splitting, merging and tie breaking,
// then random bursts of mostly well-formed allocate/free traffic with some
// malformed requests, under random response back-pressure and one long
// hold-off. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module buddy_block_allocator_unit_test;
   import bba_pkg::*;

   localparam int RANDOM_ITEMS = 1600;
   localparam int HOLD_CYCLES  = 600;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic                 req_command;
   logic [SIZE_W-1:0]    req_request_size;
   logic [OFFSET_W-1:0]  req_free_offset;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [STATUS_W-1:0]  rsp_status;
   logic [OFFSET_W-1:0]  rsp_block_offset;
   logic [SIZE_W-1:0]    rsp_block_size;
   int                   mismatches;
   int                   pending_results;

   // commands in flight and offsets of blocks currently held
   logic                 issued_cmds [$];
   logic [OFFSET_W-1:0]  live_offsets [$];
   logic [OFFSET_W-1:0]  last_freed;
   int                   items_accepted;

   buddy_block_allocator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_request_size (req_request_size),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_size   (rsp_block_size)
   );

   buddy_alloc_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_request_size (req_request_size),
      .req_free_offset  (req_free_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_status       (rsp_status),
      .rsp_block_offset (rsp_block_offset),
      .rsp_block_size   (rsp_block_size),
      .mismatch_count   (mismatches),
      .pending_results  (pending_results)
   );

   // clock, 10 ns period
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // learn allocated offsets from response beats, for well-formed frees
   always @(posedge clock) begin
      logic cmd;
      if (!reset && rsp_valid && !rsp_stall && issued_cmds.size() > 0) begin
         cmd = issued_cmds.pop_front();
         if (cmd == CMD_ALLOC && rsp_status == STATUS_OK)
            live_offsets.push_back(rsp_block_offset);
      end
   end

   // one request beat, held until accepted
   task automatic send_item(input logic cmd, input logic [SIZE_W-1:0] units,
                            input logic [OFFSET_W-1:0] off);
      @(negedge clock);
      req_valid        <= 1'b1;
      req_command      <= cmd;
      req_request_size <= units;
      req_free_offset  <= off;
      if (cmd == CMD_FREE) begin
         for (int i = live_offsets.size() - 1; i >= 0; i--)
            if (live_offsets[i] == off)
               live_offsets.delete(i);
         last_freed = off;
      end
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      issued_cmds.push_back(cmd);
      items_accepted++;
   endtask

   task automatic send_alloc(input int units);
      send_item(CMD_ALLOC, SIZE_W'(units), OFFSET_W'($urandom));
   endtask

   task automatic send_free(input int off);
      send_item(CMD_FREE, SIZE_W'($urandom), OFFSET_W'(off));
   endtask

   // sizes weighted towards small blocks so the pool rarely runs dry
   function automatic int alloc_units();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 50)      return $urandom_range(1, 32);
      else if (pick < 75) return $urandom_range(33, 128);
      else if (pick < 90) return $urandom_range(129, 512);
      else if (pick < 96) return $urandom_range(513, 1024);
      else if (pick < 98) return $urandom_range(1025, 2047);
      else                return 0;
   endfunction

   // malformed or stray requests
   task automatic send_noise();
      case ($urandom_range(0, 4))
         0: send_free($urandom_range(0, 1023));
         1: send_free($urandom_range(0, LEAVES - 1) * MIN_BLOCK);
         2: send_free(last_freed);
         3: send_alloc(0);
         default: send_alloc($urandom_range(1025, 2047));
      endcase
   endtask

   task automatic run_directed();
      send_alloc(0);        // zero size
      send_alloc(2047);     // beyond the pool
      send_alloc(1025);
      send_alloc(1024);     // whole pool
      send_alloc(1);        // nothing left
      send_free(0);         // back to one free pool
      send_free(0);         // already free
      send_free(1023);      // misaligned, every offset bit set
      send_free(992);       // aligned but not a block start
      send_alloc(1);        // split down to the minimum
      send_alloc(33);
      send_alloc(32);
      send_free(32);        // buddy still used, no merge
      send_free(0);
      send_free(64);        // merges all the way to the pool
      send_alloc(256);
      send_alloc(256);
      send_alloc(256);
      send_alloc(256);
      send_free(0);
      send_free(512);
      send_alloc(100);      // equal candidates, highest address wins
      send_alloc(512);
      send_free(16);
   endtask

   // bursts of mostly well-formed traffic with random gaps between them
   task automatic run_random();
      int sent;
      int burst;
      int pick;
      int gap;
      int idx;
      int free_share;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(1, 24);
         repeat (burst) begin
            pick       = $urandom_range(0, 99);
            free_share = (live_offsets.size() > 8) ? 65 : 45;
            if (pick < 12) begin
               send_noise();
            end else if (live_offsets.size() > 0 && pick < free_share) begin
               idx = $urandom_range(0, live_offsets.size() - 1);
               send_free(live_offsets[idx]);
            end else begin
               send_alloc(alloc_units());
            end
            sent++;
         end
         if ($urandom_range(0, 3) != 0) begin
            gap = $urandom_range(1, 12);
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1)
               @(negedge clock);
         end
      end
   endtask

   // stimulus and verdict
   initial begin
      req_valid        = 1'b0;
      req_command      = CMD_ALLOC;
      req_request_size = '0;
      req_free_offset  = '0;
      last_freed       = '0;
      items_accepted   = 0;
      reset            = 1'b1;
      repeat (10)
         @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      run_directed();
      run_random();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_results != 0)
         @(posedge clock);
      repeat (60)
         @(posedge clock);
      if (mismatches == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   // response back-pressure: free stretches, light and heavy stalling, one long hold
   initial begin
      int  mode;
      int  len;
      bit  held;
      rsp_stall = 1'b0;
      held      = 1'b0;
      forever begin
         if (!held && items_accepted >= 300) begin
            held = 1'b1;
            repeat (HOLD_CYCLES) begin
               @(negedge clock);
               rsp_stall <= 1'b1;
            end
         end else begin
            mode = $urandom_range(0, 2);
            len  = $urandom_range(20, 150);
            repeat (len) begin
               @(negedge clock);
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 2) == 0);
                  default: rsp_stall <= ($urandom_range(0, 3) != 0);
               endcase
            end
         end
      end
   end

   // run limit
   initial begin
      #10_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
